// File: sv/exponential_average_filter_top_defines.svh
// Assertion macros shared by the exponential average filter RTL.
// Included by modules that check their own control logic; needs nothing else.
`ifndef EXPONENTIAL_AVERAGE_FILTER_TOP_DEFINES_SVH
`define EXPONENTIAL_AVERAGE_FILTER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define EAF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("eaf check failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define EAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("eaf check failed: next-cycle implication");

`endif

// File: sv/eaf_pkg.sv
// Shared widths, constants and controller/datapath interface types.
// No dependencies; imported by every module of the filter.
package eaf_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SUM_W    = 32;
   localparam int K_W      = 8;
   localparam int CNT_W    = $clog2(SUM_W);

   localparam logic [K_W-1:0]      K_RESET = K_W'(8);
   localparam logic [SAMPLE_W-1:0] AVG_MAX = {SAMPLE_W{1'b1}};

   typedef struct packed {
      logic load_sample;
      logic div_start;
      logic update_sum;
      logic load_result;
   } eaf_cmd_type;

   typedef struct packed {
      logic div_done;
   } eaf_status_type;

endpackage

// File: sv/eaf_div.sv
// Restoring divider, 32-bit dividend by 8-bit divisor, one quotient bit per cycle.
// Depends on eaf_pkg; used by eaf_dp.
module eaf_div
   import eaf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [K_W-1:0]   divisor,
   output logic [SUM_W-1:0] quotient,
   output logic             done
);

   logic [K_W-1:0]   rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [K_W-1:0]   div_ff, div_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [K_W:0]     trial;
   logic [K_W:0]     diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[SUM_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[K_W-1:0] : trial[K_W-1:0];
         quo_in = {quo_ff[SUM_W-2:0], fits};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign quotient = quo_ff;
   assign done     = done_ff;

endmodule

// File: sv/eaf_dp.sv
// Datapath: smoothing factor register, scaled sum, sample and result registers.
// Depends on eaf_pkg and eaf_div; driven by eaf_ctrl commands.
module eaf_dp
   import eaf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [K_W-1:0]      csr_wr_data,
   input  logic [SAMPLE_W-1:0] req_sample,
   input  eaf_cmd_type        cmd,
   output eaf_status_type     status,
   output logic [SAMPLE_W-1:0] rsp_average
);

   logic [K_W-1:0]      k_ff, k_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [SAMPLE_W-1:0] average_ff, average_in;
   logic [K_W-1:0]      k_eff;
   logic [SUM_W-1:0]    dividend;
   logic [SUM_W-1:0]    quotient;
   logic                div_done;

   assign k_eff    = (k_ff == '0) ? K_W'(1) : k_ff;
   assign dividend = sum_ff + SUM_W'(k_eff >> 1);

   eaf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (k_eff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      k_in       = csr_wr_en ? csr_wr_data : k_ff;
      sample_in  = cmd.load_sample ? req_sample : sample_ff;
      sum_in     = cmd.update_sum ? (sum_ff + SUM_W'(sample_ff) - quotient) : sum_ff;
      average_in = average_ff;
      if (cmd.load_result) begin
         average_in = (quotient[SUM_W-1:SAMPLE_W] != '0) ? AVG_MAX
                                                         : quotient[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff   <= K_RESET;
         sum_ff <= '0;
      end else begin
         k_ff   <= k_in;
         sum_ff <= sum_in;
      end
      sample_ff  <= sample_in;
      average_ff <= average_in;
   end

   assign status.div_done = div_done;
   assign rsp_average     = average_ff;

endmodule

// File: sv/eaf_ctrl.sv
// Controller: sequences the two divisions, the sum update and the output register.
// Depends on eaf_pkg and the assertion macro header; drives eaf_dp.
`include "exponential_average_filter_top_defines.svh"

module eaf_ctrl
   import eaf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  eaf_status_type status,
   output eaf_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_DIV1   = 3'd1;
   localparam logic [2:0] ST_START2 = 3'd2;
   localparam logic [2:0] ST_DIV2   = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_sample = 1'b1;
               cmd.div_start   = 1'b1;
               state_in        = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (status.div_done) begin
               cmd.update_sum = 1'b1;
               state_in       = ST_START2;
            end
         end
         ST_START2: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV2;
         end
         ST_DIV2: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `EAF_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && req_ready, state_ff == ST_DIV1)
   `EAF_ASSERT_NOW(a_done_only_in_div, clock, reset, status.div_done, state_ff == ST_DIV1 || state_ff == ST_DIV2)
   `EAF_ASSERT_NEXT(a_result_shows, clock, reset, cmd.load_result, rsp_valid_ff)

endmodule

// File: sv/exponential_average_filter_top.sv
// Exponential moving average filter, top level.
// Depends on eaf_pkg, eaf_ctrl and eaf_dp (which holds eaf_div).
//
// Usage: a request carries one 16-bit sample on req_sample and is taken when
// req_valid and req_ready are both high. Each request yields exactly one
// response, rsp_average, taken when rsp_valid and rsp_ready are both high.
// The smoothing factor is written through csr_wr_en / csr_wr_data at any
// edge with csr_wr_en high; write it only while the filter is idle.
// An accepted request runs two 32-step passes of the bit-serial restoring
// divider with the sum update between them, then the output load. req_ready
// is high only while the controller is idle: no request is taken until the
// last is through. A response waiting in the output register does not
// block the next request; only the final load waits for the receiver.
// Reset: the scaled sum clears to zero, the smoothing factor returns to 8,
// and no response is pending.
// Stall: if rsp_ready stays low, the response is held and the next result
// waits in the controller until the output register frees.
module exponential_average_filter_top
   import eaf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [SAMPLE_W-1:0] req_sample,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_average,
   input  logic                csr_wr_en,
   input  logic [K_W-1:0]      csr_wr_data
);

   eaf_cmd_type    cmd;
   eaf_status_type status;

   eaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   eaf_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_sample  (req_sample),
      .cmd         (cmd),
      .status      (status),
      .rsp_average (rsp_average)
   );

endmodule
